/* src/btpd_pkg.sv */
package btpd_pkg;

   typedef struct packed {
      logic [15:0]        accel_sample;
      logic [15:0]        gyro_sample;
      logic signed [15:0] speed_term;
      logic signed [15:0] direction_term;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  left_drive;
      logic signed [7:0]  right_drive;
      logic signed [31:0] tilt_estimate_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] accel_zero;
      logic [15:0] gyro_zero;
      logic [15:0] accel_scale;
      logic [15:0] gyro_scale;
      logic [15:0] inv_time_const;
      logic [15:0] angle_kp;
      logic [15:0] angle_kd;
   } cfg_type;

   localparam logic [2:0] REG_ACCEL_ZERO  = 3'd0;
   localparam logic [2:0] REG_GYRO_ZERO   = 3'd1;
   localparam logic [2:0] REG_ACCEL_SCALE = 3'd2;
   localparam logic [2:0] REG_GYRO_SCALE  = 3'd3;
   localparam logic [2:0] REG_INV_TC      = 3'd4;
   localparam logic [2:0] REG_ANGLE_KP    = 3'd5;
   localparam logic [2:0] REG_ANGLE_KD    = 3'd6;

   localparam logic [2:0] GROUP_LAST = 3'd5;

   // Accumulator width of the serial multiplier (48-bit by 16-bit product).
   localparam int ACC_W = 64;

endpackage

/* src/btpd_mul.sv */
// Shift-add multiplier: signed multiplicand times unsigned 16-bit multiplier,
// one multiplier bit per cycle.
module btpd_mul
   import btpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [47:0]      mcand,
   input  logic [15:0]             mplier,
   output logic                    done,
   output logic signed [ACC_W-1:0] product
);

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mc_ff, mc_in;
   logic [15:0]             mp_ff, mp_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = ACC_W'(mcand);
         mp_in   = mplier;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff <<< 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* src/btpd_div200.sv */
// Signed divide by 200, truncating toward zero; restoring, one quotient bit
// per cycle on the magnitude.
module btpd_div200
   import btpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   output logic                    done,
   output logic signed [ACC_W-1:0] quotient
);

   localparam int NW = 50;

   logic [NW-1:0] num_ff, num_in;
   logic [8:0]    rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [ACC_W-1:0] mag;
   logic [8:0]    trial;

   always_comb begin
      mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      num_in  = num_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[7:0], num_ff[NW-1]};
      if (start) begin
         num_in  = mag[NW-1:0];
         rem_in  = '0;
         neg_in  = dividend[ACC_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= 9'd200) begin
            rem_in = trial - 9'd200;
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -ACC_W'(num_ff) : ACC_W'(num_ff);

endmodule

/* src/balance_tilt_pd_motor_drive.sv */
// Channel   Dir  Payload    Handshake
// req_      in   req_type   req_valid / req_stall
// rsp_      out  rsp_type   rsp_valid / rsp_stall
// csr_      in   index/data csr_we
// Samples 1-5 of a group are only accumulated. The sixth also runs three serial
// multiplies, a divide by 200 and two more multiplies; rsp_valid rises once the
// last multiply is done.
// Reset is synchronous and restores register defaults and zero state.
// req_stall is high while a group is computed, and at a group's last sample
// while the previous result still waits in rsp.
module balance_tilt_pd_motor_drive
   import btpd_pkg::*;
#(
   parameter int DRIVE_LIMIT = 100,
   parameter int DEAD_BAND   = 45
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_TILT = 4'd1;
   localparam logic [3:0] ST_RATE = 4'd2;
   localparam logic [3:0] ST_FILT = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_KP   = 4'd5;
   localparam logic [3:0] ST_KD   = 4'd6;

   localparam logic signed [ACC_W-1:0] ONE = ACC_W'(64'sd16777216);
   localparam logic signed [ACC_W-1:0] LIM = ACC_W'(DRIVE_LIMIT) * ONE;
   localparam logic signed [ACC_W-1:0] DB  = ACC_W'(DEAD_BAND) * ONE;

   cfg_type cfg_ff;
   logic [3:0]  st_ff;
   logic [2:0]  cnt_ff;
   logic [18:0] asum_ff, gsum_ff;
   logic [15:0] amax_ff, amin_ff, gmax_ff, gmin_ff;
   logic signed [31:0] est_ff;
   logic signed [15:0] spd_ff, dir_ff;
   logic signed [ACC_W-1:0] tilt_ff, rate_ff, drv_ff;
   logic        rv_ff;
   rsp_type     rsp_ff;
   logic        go_ff, go_in;

   logic        mdone, ddone;
   logic signed [ACC_W-1:0] prod, quot;
   logic signed [ACC_W-1:0] dividend;

   logic        take;
   logic [15:0] a, g;
   logic signed [20:0] amean, gmean;
   logic signed [ACC_W-1:0] mterm, newest, left, right;
   logic signed [7:0] lside, rside;

   function automatic logic signed [7:0] side(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      begin
         t = v;
         if (v > 0) t = v + DB;
         else if (v < 0) t = v - DB;
         if (t > LIM) t = LIM;
         if (t < -LIM) t = -LIM;
         if (t < 0) t = t + (ONE - 1);
         side = 8'(t >>> 24);
      end
   endfunction

   assign take = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || (rv_ff && cnt_ff == GROUP_LAST);
   assign a = req_data.accel_sample;
   assign g = req_data.gyro_sample;

   // trimmed means, arithmetic shift on nonnegative values
   assign amean = 21'(($signed({2'b0, asum_ff}) - $signed({5'b0, amax_ff})
                      - $signed({5'b0, amin_ff})) >>> 2);
   assign gmean = 21'(($signed({2'b0, gsum_ff}) - $signed({5'b0, gmax_ff})
                      - $signed({5'b0, gmin_ff})) >>> 2);

   // truncate toward zero on /65536
   assign mterm = prod[ACC_W-1] ? ((prod + ACC_W'(65535)) >>> 16) : (prod >>> 16);
   assign dividend = mterm + rate_ff;
   assign newest = (quot + ACC_W'(est_ff) > ACC_W'(64'sd2147483647)) ?
                   ACC_W'(64'sd2147483647) :
                   (quot + ACC_W'(est_ff) < -ACC_W'(64'sd2147483648)) ?
                   -ACC_W'(64'sd2147483648) : quot + ACC_W'(est_ff);
   assign left  = drv_ff - prod - (ACC_W'(spd_ff) <<< 16) + (ACC_W'(dir_ff) <<< 16);
   assign right = drv_ff - prod - (ACC_W'(spd_ff) <<< 16) - (ACC_W'(dir_ff) <<< 16);
   assign lside = side(left);
   assign rside = side(right);

   // one-cycle start pulse on entry to each arithmetic state
   always_comb begin
      go_in = 1'b0;
      case (st_ff)
         ST_IDLE: go_in = take && (cnt_ff == GROUP_LAST);
         ST_TILT: go_in = mdone;
         ST_RATE: go_in = mdone;
         ST_FILT: go_in = mdone;
         ST_DIV:  go_in = ddone;
         ST_KP:   go_in = mdone;
         default: go_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
         go_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         est_ff <= '0;
         asum_ff <= '0; gsum_ff <= '0;
         amax_ff <= '0; amin_ff <= '0; gmax_ff <= '0; gmin_ff <= '0;
         cfg_ff <= {16'd29620, 16'd29800, 16'd384, 16'd1442, 16'd32768,
                    16'd2560, 16'd51};
      end else begin
         go_ff <= go_in;
         if (csr_we) begin
            case (csr_index)
               REG_ACCEL_ZERO:  cfg_ff.accel_zero     <= csr_data;
               REG_GYRO_ZERO:   cfg_ff.gyro_zero      <= csr_data;
               REG_ACCEL_SCALE: cfg_ff.accel_scale    <= csr_data;
               REG_GYRO_SCALE:  cfg_ff.gyro_scale     <= csr_data;
               REG_INV_TC:      cfg_ff.inv_time_const <= csr_data;
               REG_ANGLE_KP:    cfg_ff.angle_kp       <= csr_data;
               REG_ANGLE_KD:    cfg_ff.angle_kd       <= csr_data;
               default: ;
            endcase
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (take) begin
            spd_ff <= req_data.speed_term;
            dir_ff <= req_data.direction_term;
            if (cnt_ff == '0) begin
               asum_ff <= 19'(a); gsum_ff <= 19'(g);
               amax_ff <= a; amin_ff <= a; gmax_ff <= g; gmin_ff <= g;
            end else begin
               asum_ff <= asum_ff + 19'(a);
               gsum_ff <= gsum_ff + 19'(g);
               if (a > amax_ff) amax_ff <= a;
               if (a < amin_ff) amin_ff <= a;
               if (g > gmax_ff) gmax_ff <= g;
               if (g < gmin_ff) gmin_ff <= g;
            end
            if (cnt_ff == GROUP_LAST) begin
               cnt_ff <= '0;
               st_ff  <= ST_TILT;
            end else begin
               cnt_ff <= cnt_ff + 3'd1;
            end
         end
         case (st_ff)
            ST_TILT: if (mdone) begin
               tilt_ff <= prod; st_ff <= ST_RATE;
            end
            ST_RATE: if (mdone) begin
               rate_ff <= prod; st_ff <= ST_FILT;
            end
            ST_FILT: if (mdone) begin
               st_ff <= ST_DIV;
            end
            ST_DIV: if (ddone) begin
               est_ff <= 32'(newest); st_ff <= ST_KP;
            end
            ST_KP: if (mdone) begin
               drv_ff <= -prod; st_ff <= ST_KD;
            end
            ST_KD: if (mdone) begin
               rsp_ff.left_drive        <= lside;
               rsp_ff.right_drive       <= rside;
               rsp_ff.tilt_estimate_out <= est_ff;
               rv_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: ;
         endcase
      end
   end

   logic signed [47:0] mc_sel;
   logic [15:0]        mp_sel;

   always_comb begin
      mc_sel = '0;
      mp_sel = '0;
      case (st_ff)
         ST_TILT: begin
            mc_sel = 48'($signed({1'b0, cfg_ff.accel_zero}) - amean);
            mp_sel = cfg_ff.accel_scale;
         end
         ST_RATE: begin
            mc_sel = 48'(gmean - $signed({1'b0, cfg_ff.gyro_zero}));
            mp_sel = cfg_ff.gyro_scale;
         end
         ST_FILT: begin
            mc_sel = 48'(tilt_ff - ACC_W'(est_ff));
            mp_sel = cfg_ff.inv_time_const;
         end
         ST_KP: begin
            mc_sel = 48'(est_ff);
            mp_sel = cfg_ff.angle_kp;
         end
         ST_KD: begin
            mc_sel = 48'(rate_ff);
            mp_sel = cfg_ff.angle_kd;
         end
         default: ;
      endcase
   end

   btpd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff && st_ff != ST_DIV),
      .mcand   (mc_sel),
      .mplier  (mp_sel),
      .done    (mdone),
      .product (prod)
   );

   btpd_div200 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff && st_ff == ST_DIV),
      .dividend (dividend),
      .done     (ddone),
      .quotient (quot)
   );

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !take) else $error("transfer while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> rv_ff) else $error("result dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> $stable(rsp_ff)) else $error("stalled result changed");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= GROUP_LAST) else $error("group count out of range");
`endif

endmodule
